// ----- design/e2f_pkg.sv -----
// Shared types, constants and arithmetic helpers for the 2-D Euler flux core.
package e2f_pkg;

  localparam int W          = 32;
  localparam int DIV_BITS   = 48;
  localparam int DIV_STAGES = DIV_BITS;
  localparam int LATENCY    = DIV_STAGES + 9;
  localparam int GAMMA_W    = 18;

  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;
  localparam logic signed [19:0] Q_ONE       = 20'sd65536;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_SAT = 2'd2
  } status_t;

  // One beat inside the velocity divider; the dividend registers collect the quotient.
  typedef struct packed {
    logic                   bad;
    logic [30:0]            d;
    logic signed [W-1:0]    e;
    logic                   nu;
    logic                   nv;
    logic [DIV_BITS-1:0]    au;
    logic [DIV_BITS-1:0]    av;
    logic [30:0]            ru;
    logic [30:0]            rv;
  } div_t;

  // One restoring division step for both quotients.
  function automatic div_t div_step(input div_t s);
    logic [31:0] tu;
    logic [31:0] tv;
    div_t        o;
    begin
      o  = s;
      tu = {s.ru, s.au[DIV_BITS-1]};
      tv = {s.rv, s.av[DIV_BITS-1]};
      if (tu >= {1'b0, s.d}) begin
        o.ru = 31'(tu - {1'b0, s.d});
        o.au = {s.au[DIV_BITS-2:0], 1'b1};
      end else begin
        o.ru = tu[30:0];
        o.au = {s.au[DIV_BITS-2:0], 1'b0};
      end
      if (tv >= {1'b0, s.d}) begin
        o.rv = 31'(tv - {1'b0, s.d});
        o.av = {s.av[DIV_BITS-2:0], 1'b1};
      end else begin
        o.rv = tv[30:0];
        o.av = {s.av[DIV_BITS-2:0], 1'b0};
      end
      return o;
    end
  endfunction

  // Clamp to the signed 32-bit range; the top bit flags a clamp.
  function automatic logic [32:0] sat32(input logic signed [63:0] x);
    begin
      if (x > MAX32) begin
        return {1'b1, 32'h7fff_ffff};
      end else if (x < MIN32) begin
        return {1'b1, 32'h8000_0000};
      end
      return {1'b0, x[31:0]};
    end
  endfunction

endpackage

// ----- design/e2f_div.sv -----
// Pipelined restoring divider producing both velocity quotients, one bit per stage.
module e2f_div
  import e2f_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  div_t in_d,
  output logic out_vld,
  output div_t out_d
);

  logic [DIV_STAGES-1:0] vld_r;
  div_t                  stg_r [0:DIV_STAGES-1];

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
  end

  // One quotient bit per register stage.
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        stg_r[0] <= div_step(in_d);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        stg_r[i] <= div_step(stg_r[i-1]);
      end
    end
  end

  assign out_vld = vld_r[DIV_STAGES-1];
  assign out_d   = stg_r[DIV_STAGES-1];

endmodule

// ----- design/e2f_flux.sv -----
// Multiply pipeline from velocities to pressure and the two flux vectors.
module e2f_flux
  import e2f_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  div_t                in_d,
  input  logic [GAMMA_W-1:0]  gamma,
  output logic                out_vld,
  output logic signed [W-1:0] fx_mass,
  output logic signed [W-1:0] fx_xmom,
  output logic signed [W-1:0] fx_ymom,
  output logic signed [W-1:0] fx_energy,
  output logic signed [W-1:0] fy_mass,
  output logic signed [W-1:0] fy_xmom,
  output logic signed [W-1:0] fy_ymom,
  output logic signed [W-1:0] fy_energy,
  output status_t             status
);

  logic [8:0] vld_r;

  logic signed [63:0] qu, qv;
  logic [32:0]        su, sv;

  logic signed [W-1:0] s1_u_r, s1_v_r, s1_e_r;
  logic [30:0]         s1_rho_r;
  logic                s1_bad_r, s1_ov_r;

  logic signed [63:0]  s2_pu_r, s2_pv_r;
  logic signed [W-1:0] s2_u_r, s2_v_r, s2_e_r;
  logic                s2_bad_r, s2_ov_r;

  logic [32:0]         mu_s, mv_s;
  logic signed [W-1:0] s3_mu_r, s3_mv_r, s3_u_r, s3_v_r, s3_e_r;
  logic                s3_bad_r, s3_ov_r;

  logic signed [63:0]  s4_muu_r, s4_mvv_r, s4_muv_r;
  logic signed [W-1:0] s4_mu_r, s4_mv_r, s4_u_r, s4_v_r, s4_e_r;
  logic                s4_bad_r, s4_ov_r;

  logic signed [63:0]  muu, mvv, muv, ke;
  logic [32:0]         eint_s, cross_s;
  logic signed [63:0]  s5_muu_r, s5_mvv_r;
  logic signed [W-1:0] s5_eint_r, s5_cross_r, s5_mu_r, s5_mv_r, s5_u_r, s5_v_r, s5_e_r;
  logic                s5_bad_r, s5_ov_r;

  logic signed [19:0]  g1;
  logic signed [63:0]  s6_pp_r, s6_muu_r, s6_mvv_r;
  logic signed [W-1:0] s6_cross_r, s6_mu_r, s6_mv_r, s6_u_r, s6_v_r, s6_e_r;
  logic                s6_bad_r, s6_ov_r;

  logic signed [63:0]  pres;
  logic [32:0]         h_s, xm_s, ym_s;
  logic signed [W-1:0] s7_h_r, s7_xm_r, s7_ym_r, s7_cross_r, s7_mu_r, s7_mv_r;
  logic signed [W-1:0] s7_u_r, s7_v_r;
  logic                s7_bad_r, s7_ov_r;

  logic signed [63:0]  s8_hu_r, s8_hv_r;
  logic signed [W-1:0] s8_xm_r, s8_ym_r, s8_cross_r, s8_mu_r, s8_mv_r;
  logic                s8_bad_r, s8_ov_r;

  logic [32:0]         fe_s, fye_s;

  // Signed quotients and their clamps at the divider output.
  always_comb begin
    qu = in_d.nu ? -$signed({16'b0, in_d.au}) : $signed({16'b0, in_d.au});
    qv = in_d.nv ? -$signed({16'b0, in_d.av}) : $signed({16'b0, in_d.av});
    su = sat32(qu);
    sv = sat32(qv);
  end

  // Combinational work between the product registers.
  always_comb begin
    mu_s    = sat32(s2_pu_r >>> 16);
    mv_s    = sat32(s2_pv_r >>> 16);
    muu     = s4_muu_r >>> 16;
    mvv     = s4_mvv_r >>> 16;
    muv     = s4_muv_r >>> 16;
    ke      = (muu + mvv) >>> 1;
    eint_s  = sat32(64'(s4_e_r) - ke);
    cross_s = sat32(muv);
    g1      = $signed({2'b0, gamma}) - Q_ONE;
    pres    = s6_pp_r >>> 16;
    h_s     = sat32(64'(s6_e_r) + pres);
    xm_s    = sat32(s6_muu_r + pres);
    ym_s    = sat32(s6_mvv_r + pres);
    fe_s    = sat32(s8_hu_r >>> 16);
    fye_s   = sat32(s8_hv_r >>> 16);
  end

  // Valid bits for the nine stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[7:0], in_vld};
    end
  end

  // Data path stages; each multiply lands in a register.
  always_ff @(posedge clk) begin
    s1_u_r   <= su[31:0];
    s1_v_r   <= sv[31:0];
    s1_e_r   <= in_d.e;
    s1_rho_r <= in_d.d;
    s1_bad_r <= in_d.bad;
    s1_ov_r  <= su[32] | sv[32];

    s2_pu_r  <= $signed({1'b0, s1_rho_r}) * s1_u_r;
    s2_pv_r  <= $signed({1'b0, s1_rho_r}) * s1_v_r;
    s2_u_r   <= s1_u_r;
    s2_v_r   <= s1_v_r;
    s2_e_r   <= s1_e_r;
    s2_bad_r <= s1_bad_r;
    s2_ov_r  <= s1_ov_r;

    s3_mu_r  <= mu_s[31:0];
    s3_mv_r  <= mv_s[31:0];
    s3_u_r   <= s2_u_r;
    s3_v_r   <= s2_v_r;
    s3_e_r   <= s2_e_r;
    s3_bad_r <= s2_bad_r;
    s3_ov_r  <= s2_ov_r | mu_s[32] | mv_s[32];

    s4_muu_r <= s3_mu_r * s3_u_r;
    s4_mvv_r <= s3_mv_r * s3_v_r;
    s4_muv_r <= s3_mu_r * s3_v_r;
    s4_mu_r  <= s3_mu_r;
    s4_mv_r  <= s3_mv_r;
    s4_u_r   <= s3_u_r;
    s4_v_r   <= s3_v_r;
    s4_e_r   <= s3_e_r;
    s4_bad_r <= s3_bad_r;
    s4_ov_r  <= s3_ov_r;

    s5_muu_r   <= muu;
    s5_mvv_r   <= mvv;
    s5_eint_r  <= eint_s[31:0];
    s5_cross_r <= cross_s[31:0];
    s5_mu_r    <= s4_mu_r;
    s5_mv_r    <= s4_mv_r;
    s5_u_r     <= s4_u_r;
    s5_v_r     <= s4_v_r;
    s5_e_r     <= s4_e_r;
    s5_bad_r   <= s4_bad_r;
    s5_ov_r    <= s4_ov_r | eint_s[32] | cross_s[32];

    s6_pp_r    <= s5_eint_r * g1;
    s6_muu_r   <= s5_muu_r;
    s6_mvv_r   <= s5_mvv_r;
    s6_cross_r <= s5_cross_r;
    s6_mu_r    <= s5_mu_r;
    s6_mv_r    <= s5_mv_r;
    s6_u_r     <= s5_u_r;
    s6_v_r     <= s5_v_r;
    s6_e_r     <= s5_e_r;
    s6_bad_r   <= s5_bad_r;
    s6_ov_r    <= s5_ov_r;

    s7_h_r     <= h_s[31:0];
    s7_xm_r    <= xm_s[31:0];
    s7_ym_r    <= ym_s[31:0];
    s7_cross_r <= s6_cross_r;
    s7_mu_r    <= s6_mu_r;
    s7_mv_r    <= s6_mv_r;
    s7_u_r     <= s6_u_r;
    s7_v_r     <= s6_v_r;
    s7_bad_r   <= s6_bad_r;
    s7_ov_r    <= s6_ov_r | h_s[32] | xm_s[32] | ym_s[32];

    s8_hu_r    <= s7_h_r * s7_u_r;
    s8_hv_r    <= s7_h_r * s7_v_r;
    s8_xm_r    <= s7_xm_r;
    s8_ym_r    <= s7_ym_r;
    s8_cross_r <= s7_cross_r;
    s8_mu_r    <= s7_mu_r;
    s8_mv_r    <= s7_mv_r;
    s8_bad_r   <= s7_bad_r;
    s8_ov_r    <= s7_ov_r;
  end

  // Output register; a cell with non-positive density reports zero fluxes.
  always_ff @(posedge clk) begin
    if (s8_bad_r) begin
      fx_mass   <= '0;
      fx_xmom   <= '0;
      fx_ymom   <= '0;
      fx_energy <= '0;
      fy_mass   <= '0;
      fy_xmom   <= '0;
      fy_ymom   <= '0;
      fy_energy <= '0;
      status    <= ST_BAD;
    end else begin
      fx_mass   <= s8_mu_r;
      fx_xmom   <= s8_xm_r;
      fx_ymom   <= s8_cross_r;
      fx_energy <= fe_s[31:0];
      fy_mass   <= s8_mv_r;
      fy_xmom   <= s8_cross_r;
      fy_ymom   <= s8_ym_r;
      fy_energy <= fye_s[31:0];
      status    <= (s8_ov_r | fe_s[32] | fye_s[32]) ? ST_SAT : ST_OK;
    end
  end

  assign out_vld = vld_r[8];

endmodule

// ----- design/euler_2d_flux_core.sv -----
// Each accepted start yields one out_valid beat, after the divider and multiply stages.
// Throughput: one cell per cycle; busy is always low, so start may be held every cycle.
// Depth is set by the 48-stage bit-per-stage velocity divider plus nine multiply stages.
// Reset (synchronous, active low) clears all valid bits and sets gamma to 1.4.
// Results are not back-pressured; each beat is shown for one cycle only.
module euler_2d_flux_core
  import e2f_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [W-1:0] in_density,
  input  logic signed [W-1:0] in_x_momentum,
  input  logic signed [W-1:0] in_y_momentum,
  input  logic signed [W-1:0] in_total_energy,
  input  logic                cfg_we,
  input  logic [GAMMA_W-1:0]  cfg_wdata,
  output logic                out_valid,
  output logic signed [W-1:0] out_fx_mass,
  output logic signed [W-1:0] out_fx_xmom,
  output logic signed [W-1:0] out_fx_ymom,
  output logic signed [W-1:0] out_fx_energy,
  output logic signed [W-1:0] out_fy_mass,
  output logic signed [W-1:0] out_fy_xmom,
  output logic signed [W-1:0] out_fy_ymom,
  output logic signed [W-1:0] out_fy_energy,
  output logic [1:0]          out_status
);

  logic [GAMMA_W-1:0] gamma_r;
  logic [W-1:0]       mx_abs, my_abs;
  div_t               div_in, div_out;
  logic               div_vld;
  status_t            status;

  assign busy = 1'b0;

  // Gamma register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
    end else if (cfg_we) begin
      gamma_r <= cfg_wdata;
    end
  end

  // Divider operands: magnitudes scaled by one in Q16.16, signs kept aside.
  always_comb begin
    mx_abs        = in_x_momentum[W-1] ? 32'(-in_x_momentum) : in_x_momentum;
    my_abs        = in_y_momentum[W-1] ? 32'(-in_y_momentum) : in_y_momentum;
    div_in.bad    = (in_density <= 0);
    div_in.d      = in_density[30:0];
    div_in.e      = in_total_energy;
    div_in.nu     = in_x_momentum[W-1];
    div_in.nv     = in_y_momentum[W-1];
    div_in.au     = {mx_abs, 16'b0};
    div_in.av     = {my_abs, 16'b0};
    div_in.ru     = '0;
    div_in.rv     = '0;
  end

  e2f_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start && !busy),
    .in_d    (div_in),
    .out_vld (div_vld),
    .out_d   (div_out)
  );

  e2f_flux u_flux (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (div_vld),
    .in_d      (div_out),
    .gamma     (gamma_r),
    .out_vld   (out_valid),
    .fx_mass   (out_fx_mass),
    .fx_xmom   (out_fx_xmom),
    .fx_ymom   (out_fx_ymom),
    .fx_energy (out_fx_energy),
    .fy_mass   (out_fy_mass),
    .fy_xmom   (out_fy_xmom),
    .fy_ymom   (out_fy_ymom),
    .fy_energy (out_fy_energy),
    .status    (status)
  );

  assign out_status = status;

`ifndef SYNTHESIS
  // Every result beat goes back to a start exactly one latency earlier.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result beat without matching start");

  // A rejected cell carries zero mass and energy fluxes.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_BAD) |->
      (out_fx_mass == 0 && out_fy_mass == 0 && out_fx_energy == 0 && out_fy_energy == 0))
    else $error("non-positive density with nonzero flux");

  // The cross momentum flux is shared by both directions.
  a_cross: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fx_ymom == out_fy_xmom))
    else $error("cross flux mismatch");
`endif

endmodule
